// ===== rtl/core/periodic_timer_bank_assert.svh =====
// Assertion macros for the periodic timer bank.
// Each macro checks a property on the rising clock edge, outside reset.
`ifndef PERIODIC_TIMER_BANK_ASSERT_SVH
`define PERIODIC_TIMER_BANK_ASSERT_SVH
`ifndef SYNTH
`define PTB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("timer bank check failed");
`define PTB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("timer bank check failed");
`else
`define PTB_ASSERT_SAME(label, ante, cons)
`define PTB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/ptb_pkg.sv =====
`default_nettype none

package ptb_pkg;

    // Bank size and timer width.
    localparam int MAX_TIMERS   = 16;
    localparam int PERIOD_WIDTH = 16;

    // Fixed field widths.
    localparam int INTERVAL_W = 16;
    localparam int LIMIT_W    = 5;
    localparam int ID_W       = 5;
    localparam int KIND_W     = 2;

    // Derived widths: slot index, timer count, and a compare width for both.
    localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W = $clog2(MAX_TIMERS + 1);
    localparam int CMP_W = (LIMIT_W > CNT_W) ? LIMIT_W : CNT_W;

    // Configuration port.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [0:0] REG_TIMER_LIMIT = 1'b0;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

    // Largest period a slot can hold.
    localparam logic [PERIOD_WIDTH-1:0] PERIOD_MAX = '1;

    // Command codes.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_ADD  = 1'b1;

    // Result kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_EXPIRY       = 2'd0,
        KIND_ADDED        = 2'd1,
        KIND_BAD_INTERVAL = 2'd2,
        KIND_FULL         = 2'd3
    } t_kind;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    // Contents of one timer slot.
    typedef struct packed {
        logic [PERIOD_WIDTH-1:0] period;
        logic [PERIOD_WIDTH-1:0] elapsed;
    } t_slot;

    // Control for one cell of the ring.
    typedef struct packed {
        logic                    shift;
        logic                    load;
        logic [PERIOD_WIDTH-1:0] period;
    } t_cell_ctl;

    // Clamp an interval to the slot width.
    function automatic logic [PERIOD_WIDTH-1:0] sat_period(
        input logic [INTERVAL_W-1:0] interval
    );
        logic [PERIOD_WIDTH-1:0] res;
        if (33'(interval) > 33'(PERIOD_MAX)) begin
            res = PERIOD_MAX;
        end else begin
            res = PERIOD_WIDTH'(interval);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/periodic_timer_bank.sv =====
// Channel    Direction  Handshake                Payload
// command    in         start high, busy low     i_command, i_interval
// result     out        o_valid for one cycle    o_kind, o_timer_id, o_last
// config     in         APB write, pready high   paddr, pwdata (prdata on read)
//
// An add's result appears in the cycle after acceptance and busy stays low.
// A tick keeps busy high while the slot ring turns one slot per cycle through the update
// unit, then while the flush state releases the held expiry.
// Each expiry is held until the next is found, so the last one leaves as busy falls.
// Reset is synchronous, active low: count and elapsed counts to zero, limit to 16.
// The receiver cannot stall, so results are never held back by it.
`default_nettype none
`include "periodic_timer_bank_assert.svh"

module periodic_timer_bank (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Command channel
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             i_command,
    input  wire logic [ptb_pkg::INTERVAL_W-1:0]   i_interval,
    // Result channel
    output logic                                  o_valid,
    output logic [ptb_pkg::KIND_W-1:0]            o_kind,
    output logic [ptb_pkg::ID_W-1:0]              o_timer_id,
    output logic                                  o_last,
    // Configuration port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [ptb_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [ptb_pkg::DATA_W-1:0]       pwdata,
    output logic [ptb_pkg::DATA_W-1:0]            prdata,
    output logic                                  pready
);

    localparam int N = ptb_pkg::MAX_TIMERS;

    ptb_pkg::t_state r_state, n_state;
    logic [ptb_pkg::LIMIT_W-1:0] r_limit;
    logic [ptb_pkg::CNT_W-1:0]   r_active, n_active;
    logic [ptb_pkg::IDX_W-1:0]   r_scan_idx, n_scan_idx;
    logic                        r_pend_valid, n_pend_valid;
    logic [ptb_pkg::ID_W-1:0]    r_pend_id, n_pend_id;
    logic                        r_out_valid, n_out_valid;
    ptb_pkg::t_kind              r_out_kind, n_out_kind;
    logic [ptb_pkg::ID_W-1:0]    r_out_id, n_out_id;
    logic                        r_out_last, n_out_last;

    logic accept;
    logic cfg_write;
    logic full;
    logic scan_end;
    logic load_en;
    logic shift_en;
    logic slot_active;
    logic [ptb_pkg::ID_W-1:0] scan_id;
    logic [ptb_pkg::PERIOD_WIDTH-1:0] load_period;

    ptb_pkg::t_slot    w_slot [N];
    ptb_pkg::t_cell_ctl cell_ctl [N];
    ptb_pkg::t_slot    upd_slot;
    logic              upd_expired;

    // Handshake decode.
    assign accept    = start && !busy;
    assign busy      = (r_state != ptb_pkg::ST_IDLE);
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[ptb_pkg::ADDR_W-1:2] == ptb_pkg::REG_TIMER_LIMIT);

    // Register read-back.
    always_comb begin
        if (paddr[ptb_pkg::ADDR_W-1:2] == ptb_pkg::REG_TIMER_LIMIT) begin
            prdata = ptb_pkg::DATA_W'(r_limit);
        end else begin
            prdata = '0;
        end
    end

    // The bank is full at the configured limit or at the physical size.
    assign full = (ptb_pkg::CMP_W'(r_active) >= ptb_pkg::CMP_W'(r_limit))
                  || (r_active >= ptb_pkg::CNT_W'(N));

    assign scan_end    = (r_scan_idx == ptb_pkg::IDX_W'(N - 1));
    assign slot_active = (ptb_pkg::CNT_W'(r_scan_idx) < r_active);
    assign scan_id     = ptb_pkg::ID_W'(ptb_pkg::CNT_W'(r_scan_idx) + ptb_pkg::CNT_W'(1));
    assign load_period = ptb_pkg::sat_period(i_interval);

    // The update unit sits between the head cell and the tail of the ring.
    ptb_update u_update (
        .i_slot    (w_slot[0]),
        .i_active  (slot_active),
        .o_slot    (upd_slot),
        .o_expired (upd_expired)
    );

    // Ring of slot cells: each takes its upper neighbour, the last takes the update.
    for (genvar j = 0; j < N; j++) begin : g_cell
        ptb_pkg::t_slot next_slot;
        if (j == N - 1) begin : g_tail
            assign next_slot = upd_slot;
        end else begin : g_body
            assign next_slot = w_slot[j + 1];
        end
        assign cell_ctl[j].shift  = shift_en;
        assign cell_ctl[j].load   = load_en && (r_active == ptb_pkg::CNT_W'(j));
        assign cell_ctl[j].period = load_period;
        ptb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (cell_ctl[j]),
            .i_next  (next_slot),
            .o_slot  (w_slot[j])
        );
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ptb_pkg::ST_IDLE: begin
                if (accept && (i_command == ptb_pkg::CMD_TICK)) begin
                    n_state = ptb_pkg::ST_SCAN;
                end
            end
            ptb_pkg::ST_SCAN: begin
                if (scan_end) begin
                    n_state = ptb_pkg::ST_FLUSH;
                end
            end
            ptb_pkg::ST_FLUSH: begin
                n_state = ptb_pkg::ST_IDLE;
            end
            default: begin
                n_state = ptb_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath control and results. An expiry is held until the next one is found,
    // so that the final one of a tick can be marked.
    always_comb begin
        n_active     = r_active;
        n_scan_idx   = r_scan_idx;
        n_pend_valid = r_pend_valid;
        n_pend_id    = r_pend_id;
        n_out_valid  = 1'b0;
        n_out_kind   = ptb_pkg::KIND_EXPIRY;
        n_out_id     = '0;
        n_out_last   = 1'b0;
        load_en      = 1'b0;
        shift_en     = 1'b0;
        case (r_state)
            ptb_pkg::ST_IDLE: begin
                if (accept && (i_command == ptb_pkg::CMD_ADD)) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    if (i_interval == '0) begin
                        n_out_kind = ptb_pkg::KIND_BAD_INTERVAL;
                    end else if (full) begin
                        n_out_kind = ptb_pkg::KIND_FULL;
                    end else begin
                        n_out_kind = ptb_pkg::KIND_ADDED;
                        n_out_id   = ptb_pkg::ID_W'(r_active + ptb_pkg::CNT_W'(1));
                        n_active   = r_active + ptb_pkg::CNT_W'(1);
                        load_en    = 1'b1;
                    end
                end else if (accept) begin
                    n_scan_idx   = '0;
                    n_pend_valid = 1'b0;
                end
            end
            ptb_pkg::ST_SCAN: begin
                shift_en   = 1'b1;
                n_scan_idx = r_scan_idx + ptb_pkg::IDX_W'(1);
                if (upd_expired) begin
                    n_out_valid  = r_pend_valid;
                    n_out_kind   = ptb_pkg::KIND_EXPIRY;
                    n_out_id     = r_pend_id;
                    n_pend_valid = 1'b1;
                    n_pend_id    = scan_id;
                end
            end
            ptb_pkg::ST_FLUSH: begin
                n_out_valid  = r_pend_valid;
                n_out_kind   = ptb_pkg::KIND_EXPIRY;
                n_out_id     = r_pend_id;
                n_out_last   = 1'b1;
                n_pend_valid = 1'b0;
            end
            default: begin
                n_pend_valid = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ptb_pkg::ST_IDLE;
            r_active     <= '0;
            r_scan_idx   <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_limit      <= ptb_pkg::LIMIT_RESET;
        end else begin
            r_state      <= n_state;
            r_active     <= n_active;
            r_scan_idx   <= n_scan_idx;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (cfg_write) begin
                r_limit <= pwdata[ptb_pkg::LIMIT_W-1:0];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pend_id  <= n_pend_id;
        r_out_kind <= n_out_kind;
        r_out_id   <= n_out_id;
        r_out_last <= n_out_last;
    end

    assign o_valid    = r_out_valid;
    assign o_kind     = r_out_kind;
    assign o_timer_id = r_out_id;
    assign o_last     = r_out_last;

    // Checks on the sequencer and the result stream.
    `PTB_ASSERT_NEXT(a_add_gives_last, accept && (i_command == ptb_pkg::CMD_ADD), o_valid && o_last)
    `PTB_ASSERT_SAME(a_add_kind_last, o_valid && (o_kind != ptb_pkg::KIND_EXPIRY), o_last)
    `PTB_ASSERT_NEXT(a_flush_ends, r_state == ptb_pkg::ST_FLUSH, !busy && !r_pend_valid)
    `PTB_ASSERT_SAME(a_count_bound, 1'b1, r_active <= ptb_pkg::CNT_W'(N))

endmodule

`default_nettype wire

// ===== rtl/core/ptb_cell.sv =====
`default_nettype none

module ptb_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ptb_pkg::t_cell_ctl i_ctl,
    input  wire ptb_pkg::t_slot    i_next,
    output ptb_pkg::t_slot         o_slot
);

    logic [ptb_pkg::PERIOD_WIDTH-1:0] r_period;
    logic [ptb_pkg::PERIOD_WIDTH-1:0] r_elapsed;

    // Period: taken from the neighbour while the ring turns, or loaded by an add.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_period <= i_next.period;
        end else if (i_ctl.load) begin
            r_period <= i_ctl.period;
        end
    end

    // Elapsed count: cleared by reset and by an add.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
        end else if (i_ctl.shift) begin
            r_elapsed <= i_next.elapsed;
        end else if (i_ctl.load) begin
            r_elapsed <= '0;
        end
    end

    assign o_slot.period  = r_period;
    assign o_slot.elapsed = r_elapsed;

endmodule

`default_nettype wire

// ===== rtl/core/ptb_update.sv =====
`default_nettype none

module ptb_update (
    input  wire ptb_pkg::t_slot i_slot,
    input  wire logic           i_active,
    output ptb_pkg::t_slot      o_slot,
    output logic                o_expired
);

    logic [ptb_pkg::PERIOD_WIDTH:0] sum;

    // Advance an active slot by one tick; an expired slot restarts from zero.
    always_comb begin
        sum       = {1'b0, i_slot.elapsed} + (ptb_pkg::PERIOD_WIDTH + 1)'(1);
        o_slot    = i_slot;
        o_expired = 1'b0;
        if (i_active) begin
            if (sum >= {1'b0, i_slot.period}) begin
                o_slot.elapsed = '0;
                o_expired      = 1'b1;
            end else begin
                o_slot.elapsed = sum[ptb_pkg::PERIOD_WIDTH-1:0];
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/periodic_timer_bank_tb.sv =====
`default_nettype none

module periodic_timer_bank_tb;
    import ptb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = MAX_TIMERS + 4;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 75;
    localparam logic [ADDR_W-1:0] ADDR_LIMIT = ADDR_W'(4 * int'(REG_TIMER_LIMIT));
    // One register only, so the next word lies beyond the register list.
    localparam logic [ADDR_W-1:0] ADDR_BEYOND = ADDR_W'(4);

    typedef struct packed {
        t_kind             kind;
        logic [ID_W-1:0]   id;
        logic              last;
    } t_timer_result;

    typedef enum logic {
        ROW_ITEM,
        ROW_WRITE
    } t_row_kind;

    typedef struct {
        t_row_kind         what;
        logic              cmd;
        logic [31:0]       val;
        logic [ADDR_W-1:0] addr;
        bit                typed;
        t_kind             ekind;
        logic [ID_W-1:0]   eid;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_command;
    logic [INTERVAL_W-1:0] i_interval;
    logic                  o_valid;
    logic [KIND_W-1:0]     o_kind;
    logic [ID_W-1:0]       o_timer_id;
    logic                  o_last;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    // Shadow copy of the bank: periods, elapsed counts, live timers, limit.
    logic [PERIOD_WIDTH-1:0] slot_period [MAX_TIMERS];
    logic [PERIOD_WIDTH-1:0] slot_elapsed [MAX_TIMERS];
    int                      timers_live;
    logic [LIMIT_W-1:0]      limit_shadow;

    t_timer_result fresh_results[$];
    t_timer_result awaited[$];
    t_dir_row      dir_rows[$];

    int  errors;
    int  cycle_count;
    int  n_items;
    int  n_expiries;
    int  n_added;
    int  n_rejected;
    bit  no_idle;

    periodic_timer_bank dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_command  (i_command),
        .i_interval (i_interval),
        .o_valid    (o_valid),
        .o_kind     (o_kind),
        .o_timer_id (o_timer_id),
        .o_last     (o_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic t_timer_result make_result(t_kind kind, int id, logic last);
        t_timer_result r;
        r.kind = kind;
        r.id = ID_W'(id);
        r.last = last;
        return r;
    endfunction

    // Work out the results of one item and advance the shadow bank.
    task automatic predict_item(input logic cmd, input logic [INTERVAL_W-1:0] ival);
        int eff_limit;
        logic [PERIOD_WIDTH:0] next_count;
        fresh_results.delete();
        if (cmd == CMD_ADD) begin
            eff_limit = (int'(limit_shadow) > MAX_TIMERS) ? MAX_TIMERS : int'(limit_shadow);
            if (ival == '0) begin
                fresh_results.push_back(make_result(KIND_BAD_INTERVAL, 0, 1'b1));
            end else if (timers_live >= eff_limit) begin
                fresh_results.push_back(make_result(KIND_FULL, 0, 1'b1));
            end else begin
                slot_period[timers_live] = ival;
                slot_elapsed[timers_live] = '0;
                timers_live++;
                fresh_results.push_back(make_result(KIND_ADDED, timers_live, 1'b1));
            end
        end else begin
            for (int i = 0; i < timers_live; i++) begin
                next_count = {1'b0, slot_elapsed[i]} + 1'b1;
                if (next_count >= {1'b0, slot_period[i]}) begin
                    slot_elapsed[i] = '0;
                    fresh_results.push_back(make_result(KIND_EXPIRY, i + 1, 1'b0));
                end else begin
                    slot_elapsed[i] = next_count[PERIOD_WIDTH-1:0];
                end
            end
            if (fresh_results.size() > 0) begin
                fresh_results[fresh_results.size() - 1].last = 1'b1;
            end
        end
    endtask

    // Present one item after a gap and record what it should produce.
    task automatic issue_item(input logic cmd, input logic [INTERVAL_W-1:0] ival,
                              input int gap, input bit typed, input t_timer_result typed_res);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_command <= cmd;
        i_interval <= ival;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_item(cmd, ival);
        n_items++;
        if (typed) begin
            awaited.push_back(typed_res);
        end else begin
            foreach (fresh_results[k]) awaited.push_back(fresh_results[k]);
        end
    endtask

    // Let the bank drain: no busy, nothing awaited, then its full scan time.
    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge i_clk);
        while (busy || awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write a register over the APB port, then read the limit back.
    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        logic [DATA_W-1:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_LIMIT) limit_shadow = data[LIMIT_W-1:0];
        pwrite <= 1'b0;
        penable <= 1'b0;
        paddr <= ADDR_LIMIT;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== DATA_W'(limit_shadow)) begin
            $display("%0t: limit read back: expected %0d, actual %0d",
                     $time, limit_shadow, got);
            errors++;
        end
    endtask

    task automatic item_row(input logic cmd, input logic [INTERVAL_W-1:0] ival,
                            input bit typed, input t_kind ekind, input int eid);
        t_dir_row r;
        r.what = ROW_ITEM;
        r.cmd = cmd;
        r.val = DATA_W'(ival);
        r.addr = '0;
        r.typed = typed;
        r.ekind = ekind;
        r.eid = ID_W'(eid);
        dir_rows.push_back(r);
    endtask

    task automatic write_row(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        t_dir_row r;
        r.what = ROW_WRITE;
        r.cmd = CMD_TICK;
        r.val = data;
        r.addr = addr;
        r.typed = 1'b0;
        r.ekind = KIND_EXPIRY;
        r.eid = '0;
        dir_rows.push_back(r);
    endtask

    // Every result on the port must match the oldest one awaited.
    always @(posedge i_clk) begin : result_check
        t_timer_result head;
        if (i_rst_n && o_valid) begin
            if (awaited.size() == 0) begin
                $display("%0t: result: expected none, actual kind %0d id %0d last %0d",
                         $time, o_kind, o_timer_id, o_last);
                errors++;
            end else begin
                head = awaited.pop_front();
                if (o_kind !== head.kind) begin
                    $display("%0t: kind: expected %0d, actual %0d", $time, head.kind, o_kind);
                    errors++;
                end
                if (o_timer_id !== head.id) begin
                    $display("%0t: timer id: expected %0d, actual %0d",
                             $time, head.id, o_timer_id);
                    errors++;
                end
                if (o_last !== head.last) begin
                    $display("%0t: last: expected %0d, actual %0d", $time, head.last, o_last);
                    errors++;
                end
                case (head.kind)
                    KIND_EXPIRY: n_expiries++;
                    KIND_ADDED:  n_added++;
                    default:     n_rejected++;
                endcase
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("periodic_timer_bank verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int lim;
        int gap;
        int pick;
        logic cmd;
        logic [INTERVAL_W-1:0] ival;
        logic [DATA_W-1:0] data;
        int phase_limits [PHASES];

        start <= 1'b0;
        i_command <= CMD_TICK;
        i_interval <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_rst_n <= 1'b0;
        errors = 0;
        cycle_count = 0;
        n_items = 0;
        n_expiries = 0;
        n_added = 0;
        n_rejected = 0;
        no_idle = 1'b0;
        timers_live = 0;
        limit_shadow = LIMIT_RESET;
        for (int i = 0; i < MAX_TIMERS; i++) begin
            slot_period[i] = '0;
            slot_elapsed[i] = '0;
        end
        phase_limits = '{9, 1, 13, 0, 31, 16};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: limit of zero, a zero interval, a write outside the
        // register list, a full bank, a limit above the bank size and the
        // extreme intervals. Ticks are checked against the shadow bank.
        write_row(ADDR_LIMIT, 32'd0);
        item_row(CMD_ADD, 16'd5, 1'b1, KIND_FULL, 0);
        item_row(CMD_ADD, 16'd0, 1'b1, KIND_BAD_INTERVAL, 0);
        item_row(CMD_TICK, 16'h0000, 1'b0, KIND_EXPIRY, 0);
        write_row(ADDR_BEYOND, 32'd16);
        item_row(CMD_ADD, 16'd1, 1'b1, KIND_FULL, 0);
        write_row(ADDR_LIMIT, 32'd2);
        item_row(CMD_ADD, 16'd1, 1'b1, KIND_ADDED, 1);
        item_row(CMD_ADD, 16'hFFFF, 1'b1, KIND_ADDED, 2);
        item_row(CMD_ADD, 16'd3, 1'b1, KIND_FULL, 0);
        item_row(CMD_TICK, 16'hFFFF, 1'b0, KIND_EXPIRY, 0);
        item_row(CMD_TICK, 16'h5A5A, 1'b0, KIND_EXPIRY, 0);
        write_row(ADDR_LIMIT, 32'hFFFF_FFFF);
        item_row(CMD_ADD, 16'd2, 1'b1, KIND_ADDED, 3);
        item_row(CMD_ADD, 16'd0, 1'b1, KIND_BAD_INTERVAL, 0);
        item_row(CMD_ADD, 16'h8000, 1'b1, KIND_ADDED, 4);
        item_row(CMD_ADD, 16'd3, 1'b1, KIND_ADDED, 5);
        item_row(CMD_TICK, 16'h0001, 1'b0, KIND_EXPIRY, 0);
        item_row(CMD_TICK, 16'h7FFF, 1'b0, KIND_EXPIRY, 0);
        item_row(CMD_TICK, 16'hA5A5, 1'b0, KIND_EXPIRY, 0);
        item_row(CMD_TICK, 16'h0000, 1'b0, KIND_EXPIRY, 0);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].what == ROW_WRITE) begin
                wait_quiet();
                write_reg(dir_rows[r].addr, dir_rows[r].val);
            end else begin
                issue_item(dir_rows[r].cmd, dir_rows[r].val[INTERVAL_W-1:0],
                           $urandom_range(0, 7), dir_rows[r].typed,
                           make_result(dir_rows[r].ekind, int'(dir_rows[r].eid), 1'b1));
            end
        end

        // Random part: mostly ticks over short periods, adds now and then,
        // with the limit moved between phases.
        for (int p = 0; p < PHASES; p++) begin
            lim = (p == 3) ? $urandom_range(0, 31) : phase_limits[p];
            data = $urandom;
            data[LIMIT_W-1:0] = LIMIT_W'(lim);
            wait_quiet();
            write_reg(ADDR_LIMIT, data);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 15) == 0) no_idle = !no_idle;
                gap = no_idle ? 0 : $urandom_range(0, 7);
                cmd = ($urandom_range(0, 99) < 20) ? CMD_ADD : CMD_TICK;
                pick = $urandom_range(0, 99);
                if (cmd == CMD_TICK) begin
                    ival = INTERVAL_W'($urandom);
                end else if (pick < 60) begin
                    ival = INTERVAL_W'($urandom_range(1, 6));
                end else if (pick < 75) begin
                    ival = INTERVAL_W'($urandom_range(7, 40));
                end else if (pick < 85) begin
                    ival = '0;
                end else begin
                    ival = INTERVAL_W'($urandom);
                end
                issue_item(cmd, ival, gap, 1'b0, make_result(KIND_EXPIRY, 0, 1'b0));
            end
        end

        wait_quiet();

        $display("Sent %0d items over %0d limit settings; %0d timers live at the end.",
                 n_items, PHASES + 3, timers_live);
        $display("Checked %0d expiries, %0d accepted adds and %0d rejected adds.",
                 n_expiries, n_added, n_rejected);
        if (errors == 0) begin
            $display("periodic_timer_bank verification clean");
        end else begin
            $display("periodic_timer_bank verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
